FILE: sv/pmffs_pkg.sv
// pmffs_pkg: opcodes, result-source codes, pipeline control struct and
// default sizes for the physical memory with free frame stack.
// No dependencies.
package pmffs_pkg;

    localparam int unsigned MEM_BYTES_DEF  = 65536;
    localparam int unsigned PAGE_BYTES_DEF = 256;
    localparam int unsigned MAX_FRAMES_DEF = 256;

    localparam int unsigned CFG_SIZE_W = 17;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 24;

    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_TAKE   = 3'd2,
        OP_RETURN = 3'd3,
        OP_FORMAT = 3'd4
    } op_t;

    typedef enum logic {
        REG_MEM_SIZE      = 1'b0,
        REG_RANDOM_ACCESS = 1'b1
    } cfg_reg_t;

    // where the result of an item comes from once the memories have answered
    typedef enum logic [1:0] {
        SRC_NONE  = 2'd0,
        SRC_MEM   = 2'd1,
        SRC_STACK = 2'd2,
        SRC_FRESH = 2'd3
    } src_t;

    typedef struct packed {
        src_t       src;
        logic       status;
        logic [7:0] fresh_frame;
    } s2_ctrl_t;

endpackage

FILE: sv/physical_memory_with_free_frame_stack.sv
// physical_memory_with_free_frame_stack: byte memory with address check and
// a stack-over-fresh-run page frame allocator, one synchronous ram for each.
// Depends on pmffs_pkg.

// One transfer in gives one transfer out, through the stage-two registers and
// the output register; a new item is taken every cycle while the output side
// is ready. All state changes (byte write, stack push or pop, counters) happen
// in the cycle an item is taken; the byte ram or stack ram read port delivers
// its data in the next cycle, where the result is formed for the output
// register. After reset the byte ram is swept to zero one byte per cycle over
// min(MEM_BYTES, 65536) bytes; s_axis_tready stays low until the sweep is done,
// while configuration writes are taken at any time. The user must change
// configuration only while no item is in flight; the block does not enforce it.
module physical_memory_with_free_frame_stack #(
    parameter int unsigned MEM_BYTES  = pmffs_pkg::MEM_BYTES_DEF,
    parameter int unsigned PAGE_BYTES = pmffs_pkg::PAGE_BYTES_DEF,
    parameter int unsigned MAX_FRAMES = pmffs_pkg::MAX_FRAMES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // opcode[2:0], address[18:3], write_data[26:19], frame_in[34:27], zero fill
    input  logic [pmffs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // read_data[7:0], frame_number[15:8], status[16], zero fill
    output logic [pmffs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [pmffs_pkg::CFG_SIZE_W-1:0]    cfg_wdata
);
    import pmffs_pkg::*;

    localparam int unsigned MEM_DEPTH = (MEM_BYTES < 65536) ? MEM_BYTES : 65536;
    localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
    localparam int unsigned SI_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int unsigned CNT_W     = $clog2(MAX_FRAMES + 1);
    localparam int unsigned PG_W      = $clog2(PAGE_BYTES + 1);
    localparam int unsigned PROD_W    = CNT_W + 1 + PG_W;
    localparam int unsigned CMP_W     = (PROD_W > CFG_SIZE_W) ? PROD_W : CFG_SIZE_W;
    localparam int unsigned BIG_W     = 26;

    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MEM_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_FRAMES);
    localparam logic [BIG_W-1:0]  MEM_BIG  = BIG_W'(MEM_BYTES);
    localparam logic [CMP_W-1:0]  PAGE_CMP = CMP_W'(PAGE_BYTES);

    // rams
    logic [7:0] mem_bytes [MEM_DEPTH];
    logic [7:0] ret_stack [MAX_FRAMES];

    // configuration
    logic [CFG_SIZE_W-1:0] mem_size_reg;
    logic                  random_access_reg;

    // allocator and sweep state
    logic [CNT_W-1:0]  stack_count_reg, stack_count_next;
    logic [CNT_W-1:0]  fresh_next_reg, fresh_next_next;
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // pipeline
    logic                  s2_valid_reg;
    s2_ctrl_t              s2_ctrl_reg, s2_ctrl_next;
    logic [7:0]            mem_rdata_reg;
    logic [7:0]            stk_rdata_reg;
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    // item fields
    op_t         in_op;
    logic [15:0] in_addr;
    logic [7:0]  in_wdata;
    logic [7:0]  in_frame;

    logic                  acc;
    logic                  s2_advance;
    logic [CFG_SIZE_W-1:0] size_eff;
    logic                  addr_ok;
    logic [CNT_W:0]        fresh_inc;
    logic [CMP_W-1:0]      fresh_end;
    logic                  fresh_ok;
    logic                  have_frames;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              stk_we, stk_re;
    logic [SI_W-1:0]   stk_waddr, stk_raddr;

    logic [7:0] res_rdata, res_frame;

    assign in_op    = op_t'(s_axis_tdata[2:0]);
    assign in_addr  = s_axis_tdata[18:3];
    assign in_wdata = s_axis_tdata[26:19];
    assign in_frame = s_axis_tdata[34:27];

    assign s2_advance    = s2_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !clearing_reg && (!s2_valid_reg || s2_advance);
    assign acc           = s_axis_tvalid && s_axis_tready;

    // size in effect is the smaller of the register and the built memory
    assign size_eff = (BIG_W'(mem_size_reg) < MEM_BIG) ? mem_size_reg
                                                      : MEM_BIG[CFG_SIZE_W-1:0];
    assign addr_ok  = {1'b0, in_addr} < size_eff;

    // fresh frame n is free when n is below MAX_FRAMES and (n + 1) pages fit in the size in effect
    assign fresh_inc   = {1'b0, fresh_next_reg} + (CNT_W + 1)'(1);
    assign fresh_end   = CMP_W'(fresh_inc) * PAGE_CMP;
    assign fresh_ok    = (fresh_next_reg < CNT_MAX) && (fresh_end <= CMP_W'(size_eff));
    assign have_frames = PAGE_CMP <= CMP_W'(size_eff);

    always_comb
    begin
        stack_count_next = stack_count_reg;
        fresh_next_next  = fresh_next_reg;
        s2_ctrl_next     = '{src: SRC_NONE, status: 1'b1, fresh_frame: 8'd0};
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = in_addr[ADDR_W-1:0];
        mem_wdata        = in_wdata;
        stk_we           = 1'b0;
        stk_re           = 1'b0;
        stk_waddr        = stack_count_reg[SI_W-1:0];
        stk_raddr        = SI_W'(stack_count_reg - CNT_W'(1));

        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = 8'd0;
        end
        else if (acc)
        begin
            case (in_op)
                OP_READ:
                begin
                    if (addr_ok)
                    begin
                        mem_re              = 1'b1;
                        s2_ctrl_next.src    = SRC_MEM;
                        s2_ctrl_next.status = 1'b0;
                    end
                end
                OP_WRITE:
                begin
                    if (addr_ok)
                    begin
                        mem_we              = 1'b1;
                        s2_ctrl_next.status = 1'b0;
                    end
                end
                OP_TAKE:
                begin
                    if (stack_count_reg != '0)
                    begin
                        stk_re              = 1'b1;
                        stack_count_next    = stack_count_reg - CNT_W'(1);
                        s2_ctrl_next.src    = SRC_STACK;
                        s2_ctrl_next.status = 1'b0;
                    end
                    else if (fresh_ok)
                    begin
                        fresh_next_next          = fresh_next_reg + CNT_W'(1);
                        s2_ctrl_next.src         = SRC_FRESH;
                        s2_ctrl_next.status      = 1'b0;
                        s2_ctrl_next.fresh_frame = 8'(fresh_next_reg);
                    end
                end
                OP_RETURN:
                begin
                    if (stack_count_reg < CNT_MAX)
                    begin
                        stk_we              = 1'b1;
                        stack_count_next    = stack_count_reg + CNT_W'(1);
                        s2_ctrl_next.status = 1'b0;
                    end
                end
                OP_FORMAT:
                begin
                    if (have_frames)
                    begin
                        stack_count_next    = '0;
                        fresh_next_next     = '0;
                        s2_ctrl_next.status = 1'b0;
                    end
                end
                default:
                begin
                    s2_ctrl_next.status = 1'b1;
                end
            endcase
        end
    end

    // byte ram, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_bytes[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= mem_bytes[in_addr[ADDR_W-1:0]];
    end

    // returned frame stack; a push and a pop never fall in the same cycle
    always_ff @(posedge clk)
    begin
        if (stk_we)
            ret_stack[stk_waddr] <= in_frame;
        if (stk_re)
            stk_rdata_reg <= ret_stack[stk_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_size_reg      <= CFG_SIZE_W'(65536);
            random_access_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MEM_SIZE:      mem_size_reg      <= cfg_wdata;
                REG_RANDOM_ACCESS: random_access_reg <= cfg_wdata[0];
                default:           mem_size_reg      <= mem_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg <= '0;
            fresh_next_reg  <= '0;
            clearing_reg    <= 1'b1;
            clr_addr_reg    <= '0;
            s2_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            stack_count_reg <= stack_count_next;
            fresh_next_reg  <= fresh_next_next;
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == CLR_LAST)
                    clearing_reg <= 1'b0;
            end
            if (acc)
                s2_valid_reg <= 1'b1;
            else if (s2_advance)
                s2_valid_reg <= 1'b0;
            if (s2_advance)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        res_rdata = 8'd0;
        res_frame = 8'd0;
        case (s2_ctrl_reg.src)
            SRC_MEM:   res_rdata = mem_rdata_reg;
            SRC_STACK: res_frame = stk_rdata_reg;
            SRC_FRESH: res_frame = s2_ctrl_reg.fresh_frame;
            default:   res_frame = 8'd0;
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (acc)
            s2_ctrl_reg <= s2_ctrl_next;
        if (s2_advance)
            m_data_reg <= {7'd0, s2_ctrl_reg.status, res_frame, res_rdata};
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // the cursor of a sequential device has no visible effect on results
    logic unused_cfg;
    assign unused_cfg = random_access_reg;

    a_no_take_while_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s_axis_tready)
        else $error("item taken during memory sweep");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stack_count_reg <= CNT_MAX && fresh_next_reg <= CNT_MAX)
        else $error("allocator counter out of range");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        acc && in_op == OP_TAKE && stack_count_reg != '0
        |=> stack_count_reg == $past(stack_count_reg) - CNT_W'(1))
        else $error("pop did not lower the stack count");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> s2_valid_reg)
        else $error("taken item lost before output stage");

    a_no_fresh_with_stack: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_ctrl_reg.src == SRC_FRESH |-> $past(stack_count_reg) == '0
        || !$past(acc))
        else $error("fresh frame handed out while stack held frames");

endmodule

FILE: dv/tb_physical_memory_with_free_frame_stack.sv
// Testbench for physical_memory_with_free_frame_stack: byte reads and writes,
// frame take, return and format, checked against an in-bench model of the
// memory and the free list. Depends on pmffs_pkg and the block itself.
`timescale 1ns / 1ps

module tb_physical_memory_with_free_frame_stack;

    import pmffs_pkg::*;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [7:0]  frame_in;
    } mem_req_t;

    typedef struct {
        logic [7:0] rdata;
        logic [7:0] frame;
        logic       status;
    } mem_rsp_t;

    localparam int unsigned N_PHASES = 8;

    // phase 3 is the long stack fill and drain, run with no idling on either side
    localparam int unsigned FILL_PHASE = 3;
    localparam int unsigned FEW_FRAMES_PHASE = 4;
    localparam int unsigned NO_FRAMES_PHASE = 1;

    localparam int unsigned HOLD_AFTER  = 500;
    localparam int unsigned HOLD_CYCLES = 300;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // opcode[2:0], address[18:3], write_data[26:19], frame_in[34:27], zero fill
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // read_data[7:0], frame_number[15:8], status[16], zero fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = REG_MEM_SIZE;
    logic [CFG_SIZE_W-1:0] cfg_wdata = '0;

    physical_memory_with_free_frame_stack dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    // model state
    logic [7:0]            mem_image [0:MEM_BYTES_DEF-1];
    logic [7:0]            free_stack [0:MAX_FRAMES_DEF-1];
    int unsigned           stack_depth;
    int unsigned           fresh_next;
    logic [15:0]           cursor_pos;
    logic [CFG_SIZE_W-1:0] size_reg;
    logic                  random_mode;

    mem_req_t    req_pending_q[$];
    mem_rsp_t    rsp_expected_q[$];
    mem_req_t    req_on_bus;
    int unsigned items_queued = 0;
    int unsigned results_seen = 0;
    int unsigned fail_count = 0;
    bit          idle_off = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;

    int unsigned phase_size [N_PHASES] = '{65536, 0, 1, 131071, 1000, 256, 65535, 300};
    bit          phase_mode [N_PHASES] = '{1, 0, 1, 0, 0, 1, 1, 0};
    int unsigned phase_mixed [N_PHASES] = '{250, 60, 60, 0, 250, 150, 200, 150};

    function automatic int unsigned size_eff();
        return (size_reg > MEM_BYTES_DEF) ? MEM_BYTES_DEF : int'(size_reg);
    endfunction

    function automatic int unsigned frames_avail();
        int unsigned n;
        n = size_eff() / PAGE_BYTES_DEF;
        return (n > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : n;
    endfunction

    function automatic mem_rsp_t apply_request(input mem_req_t rq);
        mem_rsp_t rs;
        rs.rdata  = 8'h00;
        rs.frame  = 8'h00;
        rs.status = 1'b1;
        case (rq.op)
            OP_READ, OP_WRITE:
            begin
                if (rq.addr < size_eff())
                begin
                    if (rq.op == OP_READ)
                        rs.rdata = mem_image[rq.addr];
                    else
                        mem_image[rq.addr] = rq.wdata;
                    if (!random_mode)
                        cursor_pos = rq.addr;
                    rs.status = 1'b0;
                end
            end
            OP_TAKE:
            begin
                // returned frames are served before the fresh run
                if (stack_depth > 0)
                begin
                    stack_depth--;
                    rs.frame  = free_stack[stack_depth];
                    rs.status = 1'b0;
                end
                else if (fresh_next < frames_avail())
                begin
                    rs.frame  = 8'(fresh_next);
                    fresh_next++;
                    rs.status = 1'b0;
                end
            end
            OP_RETURN:
            begin
                if (stack_depth < MAX_FRAMES_DEF)
                begin
                    free_stack[stack_depth] = rq.frame_in;
                    stack_depth++;
                    rs.status = 1'b0;
                end
            end
            OP_FORMAT:
            begin
                if (frames_avail() > 0)
                begin
                    stack_depth = 0;
                    fresh_next  = 0;
                    rs.status   = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        return rs;
    endfunction

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] pick_addr();
        int unsigned sz;
        int unsigned r;
        sz = size_eff();
        r  = $urandom_range(99);
        if (r < 35 || sz == 0)
            return 16'($urandom);
        if (r < 55)
            return 16'(sz - 1 + $urandom_range(2));  // last valid byte and the two just past it
        if (r < 80)
            return 16'($urandom_range(31));
        return 16'($urandom_range(sz - 1));
    endfunction

    task automatic add_req(input logic [2:0] op, input logic [15:0] addr,
                           input logic [7:0] wdata, input logic [7:0] fin);
        mem_req_t rq;
        rq.op       = op;
        rq.addr     = addr;
        rq.wdata    = wdata;
        rq.frame_in = fin;
        req_pending_q.push_back(rq);
        items_queued++;
    endtask

    task automatic queue_mixed(input int unsigned count);
        int unsigned start;
        int unsigned kind;
        int unsigned len;
        logic [15:0] a;
        start = items_queued;
        while (items_queued - start < count)
        begin
            kind = $urandom_range(99);
            len  = $urandom_range(1, 8);
            if (kind < 30)
            begin
                a = pick_addr();
                add_req(OP_WRITE, a, rnd_byte(), rnd_byte());
                repeat ($urandom_range(1, 3))
                    add_req(OP_READ, a, rnd_byte(), rnd_byte());
            end
            else if (kind < 45)
                add_req($urandom_range(1) ? OP_WRITE : OP_READ, pick_addr(), rnd_byte(),
                        rnd_byte());
            else if (kind < 60)
                repeat (len)
                    add_req(OP_TAKE, 16'($urandom), rnd_byte(), rnd_byte());
            else if (kind < 72)
                repeat (len)
                    add_req(OP_RETURN, 16'($urandom), rnd_byte(), rnd_byte());
            else if (kind < 77)
                add_req(OP_FORMAT, 16'($urandom), rnd_byte(), rnd_byte());
            else if (kind < 80)
                add_req(3'(OP_FORMAT) + 3'(1 + $urandom_range(2)), 16'($urandom),
                        rnd_byte(), rnd_byte());
            else if (kind < 85)
                add_req(3'($urandom), 16'($urandom), rnd_byte(), rnd_byte());
            else
            begin
                // a return followed at once by a take gives back the same frame when the stack has room
                add_req(OP_RETURN, 16'($urandom), rnd_byte(), rnd_byte());
                add_req(OP_TAKE, 16'($urandom), rnd_byte(), rnd_byte());
            end
        end
    endtask

    task automatic write_config(input int unsigned sz, input bit mode);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MEM_SIZE;
        cfg_wdata <= CFG_SIZE_W'(sz);
        size_reg   = CFG_SIZE_W'(sz);
        @(posedge clk);
        cfg_index <= REG_RANDOM_ACCESS;
        cfg_wdata <= CFG_SIZE_W'(mode);
        random_mode = mode;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // stimulus sender
    always @(posedge clk)
    begin : drive_proc
        logic fire;
        fire = s_axis_tvalid && s_axis_tready;
        if (fire)
            rsp_expected_q.push_back(apply_request(req_on_bus));
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || fire)
        begin
            if (req_pending_q.size() > 0 && (idle_off || $urandom_range(99) >= 15))
            begin
                req_on_bus = req_pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {5'b0, req_on_bus.frame_in, req_on_bus.wdata,
                                  req_on_bus.addr, req_on_bus.op};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result receiver and checker
    always @(posedge clk)
    begin : sink_proc
        mem_rsp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (rsp_expected_q.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected transfer, expected none, got %06h", $time,
                         m_axis_tdata);
            end
            else
            begin
                want = rsp_expected_q.pop_front();
                results_seen++;
                if (m_axis_tdata[7:0] !== want.rdata)
                begin
                    fail_count++;
                    $display("%0t: read_data expected %02h got %02h", $time, want.rdata,
                             m_axis_tdata[7:0]);
                end
                if (m_axis_tdata[15:8] !== want.frame)
                begin
                    fail_count++;
                    $display("%0t: frame_number expected %02h got %02h", $time, want.frame,
                             m_axis_tdata[15:8]);
                end
                if (m_axis_tdata[16] !== want.status)
                begin
                    fail_count++;
                    $display("%0t: status expected %0b got %0b", $time, want.status,
                             m_axis_tdata[16]);
                end
            end
        end
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER && req_pending_q.size() > 50)
        begin
            // long back-pressure so the pipeline fills and the input stalls
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= idle_off || $urandom_range(99) >= 15;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : main_proc
        int unsigned sz;
        for (int i = 0; i < MEM_BYTES_DEF; i++)
            mem_image[i] = 8'h00;
        stack_depth = 0;
        fresh_next  = 0;
        cursor_pos  = '0;
        size_reg    = CFG_SIZE_W'(MEM_BYTES_DEF);
        random_mode = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            wait (results_seen == items_queued);
            write_config(phase_size[ph], phase_mode[ph]);
            idle_off = (ph == FILL_PHASE);
            sz = size_eff();
            if (ph == 0)
            begin
                add_req(OP_READ, 16'h0000, 8'h00, 8'h00);
                add_req(OP_WRITE, 16'h0000, 8'hff, 8'hff);
                add_req(OP_READ, 16'h0000, 8'h00, 8'h00);
                add_req(OP_WRITE, 16'hffff, 8'ha5, 8'h00);
                add_req(OP_READ, 16'hffff, 8'hff, 8'hff);
                add_req(OP_WRITE, 16'h1234, 8'h00, 8'h5a);
                add_req(OP_READ, 16'h1234, 8'h00, 8'h00);
                add_req(OP_TAKE, 16'h0000, 8'h00, 8'h00);
                add_req(OP_TAKE, 16'hffff, 8'hff, 8'hff);
                add_req(OP_RETURN, 16'h0000, 8'h00, 8'hff);
                add_req(OP_RETURN, 16'h0000, 8'h00, 8'h00);
                add_req(OP_TAKE, 16'h0000, 8'h00, 8'h00);
                add_req(OP_TAKE, 16'h0000, 8'h00, 8'h00);
                add_req(OP_TAKE, 16'h0000, 8'h00, 8'h00);
                add_req(OP_FORMAT, 16'h0000, 8'h00, 8'h00);
                add_req(OP_TAKE, 16'h0000, 8'h00, 8'h00);
                add_req(3'(OP_FORMAT) + 3'd1, 16'h0000, 8'h00, 8'h00);
                add_req(3'(OP_FORMAT) + 3'd2, 16'hffff, 8'hff, 8'hff);
                add_req(3'(OP_FORMAT) + 3'd3, 16'h0000, 8'h00, 8'h00);
            end
            else if (ph == NO_FRAMES_PHASE)
            begin
                // no frames at all: format fails and keeps the stack
                add_req(OP_RETURN, 16'h0000, 8'h00, 8'h3c);
                add_req(OP_FORMAT, 16'h0000, 8'h00, 8'h00);
                add_req(OP_TAKE, 16'h0000, 8'h00, 8'h00);
                add_req(OP_TAKE, 16'h0000, 8'h00, 8'h00);
            end
            else if (ph == FEW_FRAMES_PHASE)
            begin
                // three frames, so the fourth take finds the list empty
                add_req(OP_FORMAT, 16'h0000, 8'h00, 8'h00);
                repeat (frames_avail() + 1)
                    add_req(OP_TAKE, 16'($urandom), rnd_byte(), rnd_byte());
            end
            else if (ph == FILL_PHASE)
            begin
                add_req(OP_FORMAT, 16'($urandom), rnd_byte(), rnd_byte());
                repeat (MAX_FRAMES_DEF + 4)
                    add_req(OP_RETURN, 16'($urandom), rnd_byte(), rnd_byte());
                repeat (MAX_FRAMES_DEF + 6)
                    add_req(OP_TAKE, 16'($urandom), rnd_byte(), rnd_byte());
            end
            // top of the address range for this size
            add_req(OP_READ, 16'(sz - 1), rnd_byte(), rnd_byte());
            add_req(OP_WRITE, 16'(sz - 1), rnd_byte(), rnd_byte());
            add_req(OP_READ, 16'(sz - 1), rnd_byte(), rnd_byte());
            add_req(OP_READ, 16'(sz), rnd_byte(), rnd_byte());
            add_req(OP_WRITE, 16'(sz), rnd_byte(), rnd_byte());
            queue_mixed(phase_mixed[ph]);
        end

        wait (results_seen == items_queued);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && rsp_expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
